[rtl/mdtm_pkg.sv]
// shared types, codes and constants of the deadline timer manager
// no dependencies; used through scoped names by every rtl file except mdtm_if
package mdtm_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam logic [31:0] ROLLOVER_DEF = 32'd3600000;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_RESET   = 3'd3;
    localparam logic [2:0] OP_SCAN    = 3'd4;
    localparam logic [2:0] OP_QUERY   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INACTIVE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic rd_id;
        logic sweep_start;
        logic sweep_step;
        logic scan_begin;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_read;
        logic needs_sweep;
        logic reset_go;
        logic sweep_done;
        logic scan_setup;
        logic any_active;
        logic out_free;
        logic res_last;
    } status_t;

endpackage

[rtl/mdtm_if.sv]
// channel interfaces of the deadline timer manager: request, response, config
// depends on nothing
interface mdtm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] now_ms;
    logic [3:0]  timer_id;
    logic [31:0] interval_ms;
    logic        recurring;
    logic        restart_now;
    modport source (output valid, operation, now_ms, timer_id, interval_ms, recurring,
                    restart_now, input ready);
    modport sink (input valid, operation, now_ms, timer_id, interval_ms, recurring,
                  restart_now, output ready);
endinterface

interface mdtm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic        expired;
    logic        front_notice;
    logic [63:0] delay_ms;
    logic        last;
    modport source (output valid, status, slot_out, expired, front_notice, delay_ms, last,
                    input ready);
    modport sink (input valid, status, slot_out, expired, front_notice, delay_ms, last,
                  output ready);
endinterface

interface mdtm_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/mdtm_ctrl.sv]
// sequencing state machine of the deadline timer manager
// depends on mdtm_pkg
module mdtm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  mdtm_pkg::status_t st,
    output mdtm_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PREP   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.calc = 1'b1;
                if (st.needs_read)
                begin
                    cmd.rd_id = 1'b1;
                    state_next = S_DECIDE;
                end
                else if (st.needs_sweep)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_DECIDE:
            begin
                cmd.calc = 1'b1;
                if (st.reset_go)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (st.sweep_done)
                begin
                    if (st.scan_setup && st.any_active)
                    begin
                        cmd.scan_begin = 1'b1;
                        cmd.sweep_start = 1'b1;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.res_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next = S_SWEEP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/mdtm_datapath.sv]
// slot tables, sweep unit, arithmetic and result register of the timer manager
// depends on mdtm_pkg
module mdtm_datapath #(
    parameter int NUM_TIMERS = mdtm_pkg::NUM_TIMERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mdtm_pkg::cmd_t    cmd,
    output mdtm_pkg::status_t st,
    input  logic [2:0]        operation,
    input  logic [63:0]       now_ms,
    input  logic [3:0]        timer_id,
    input  logic [31:0]       interval_ms,
    input  logic              recurring,
    input  logic              restart_now,
    input  logic              cfg_valid,
    input  logic [31:0]       cfg_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [1:0]        status,
    output logic [3:0]        slot_out,
    output logic              expired,
    output logic              front_notice,
    output logic [63:0]       delay_ms,
    output logic              last
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam logic [3:0] LAST_CNT = 4'(mdtm_pkg::MAX_RESULTS - 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

    // latched item
    logic [2:0]  op_reg;
    logic [63:0] now_reg;
    logic [3:0]  id_reg;
    logic [31:0] ivl_reg;
    logic        rec_reg;
    logic        fnow_reg;

    // slot state
    logic        active_reg [NUM_TIMERS];
    logic        rep_reg [NUM_TIMERS];
    logic        due_reg [NUM_TIMERS];
    logic [63:0] dl_mem [NUM_TIMERS];
    logic [31:0] ivl_mem [NUM_TIMERS];
    logic [63:0] last_scan_reg;
    logic        pending_reg;
    logic [31:0] rollover_reg;

    // per item work registers
    logic [63:0] new_dl_reg;
    logic [64:0] roll_sum_reg;
    logic        short_reg;
    logic        scan_sel_reg;
    logic [3:0]  emit_cnt_reg;

    // sweep unit
    logic [IW-1:0] idx_reg;
    logic          iss_done_reg;
    logic          p_vld_reg;
    logic [IW-1:0] p_idx_reg;
    logic [63:0]   rd_dl_reg;
    logic [31:0]   rd_ivl_reg;

    // accumulators
    logic          found_reg;
    logic [63:0]   best_dl_reg;
    logic [IW-1:0] best_idx_reg;
    logic [31:0]   best_ivl_reg;
    logic          best_rep_reg;
    logic          more_reg;
    logic          block_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic          any_reg;

    // result register
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [3:0]  slot_reg;
    logic        expired_reg;
    logic        notice_reg;
    logic [63:0] delay_reg;
    logic        last_reg;

    logic [IW-1:0] id_idx;
    logic          id_ok;
    logic          id_act;
    logic          short_w;
    logic          issue;
    logic [IW-1:0] rd_addr;
    logic          p_act;
    logic          p_rep;
    logic          roll_w;
    logic          out_free;

    // emit decisions
    logic [1:0]    r_status;
    logic [3:0]    r_slot;
    logic          r_exp;
    logic          r_notice;
    logic [63:0]   r_delay;
    logic          r_last;
    logic          wr_dl_en;
    logic [IW-1:0] wr_dl_addr;
    logic [63:0]   wr_dl_data;
    logic          wr_ivl_en;
    logic [IW-1:0] wr_ivl_addr;
    logic          act_set;
    logic          act_clr;
    logic [IW-1:0] act_addr;
    logic          rep_wr;
    logic          due_clr;
    logic          pend_set;
    logic          pend_clr;
    logic          cnt_inc;

    assign id_idx  = IW'(id_reg);
    assign id_ok   = 32'(id_reg) < 32'(NUM_TIMERS);
    assign id_act  = active_reg[id_idx];
    assign short_w = (ivl_reg == rd_ivl_reg) && !fnow_reg;
    assign issue   = cmd.sweep_step && !iss_done_reg;
    assign rd_addr = cmd.rd_id ? id_idx : idx_reg;
    assign p_act   = active_reg[p_idx_reg];
    assign p_rep   = rep_reg[p_idx_reg];
    // last - now > rollover, with now + rollover registered earlier under calc
    assign roll_w  = {1'b0, last_scan_reg} > roll_sum_reg;
    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        st.needs_read  = (op_reg == mdtm_pkg::OP_REFRESH) || (op_reg == mdtm_pkg::OP_RESET);
        st.needs_sweep = (op_reg == mdtm_pkg::OP_ADD) || (op_reg == mdtm_pkg::OP_SCAN)
                         || (op_reg == mdtm_pkg::OP_QUERY);
        st.reset_go    = (op_reg == mdtm_pkg::OP_RESET) && id_ok && !short_w && id_act;
        st.sweep_done  = iss_done_reg && !p_vld_reg;
        st.scan_setup  = (op_reg == mdtm_pkg::OP_SCAN) && !scan_sel_reg;
        st.any_active  = any_reg;
        st.out_free    = out_free;
        st.res_last    = r_last;
    end

    // result and side effects of the current item
    always_comb
    begin
        r_status    = mdtm_pkg::ST_OK;
        r_slot      = '0;
        r_exp       = 1'b0;
        r_notice    = 1'b0;
        r_delay     = '0;
        r_last      = 1'b1;
        wr_dl_en    = 1'b0;
        wr_dl_addr  = id_idx;
        wr_dl_data  = new_dl_reg;
        wr_ivl_en   = 1'b0;
        wr_ivl_addr = id_idx;
        act_set     = 1'b0;
        act_clr     = 1'b0;
        act_addr    = id_idx;
        rep_wr      = 1'b0;
        due_clr     = 1'b0;
        pend_set    = 1'b0;
        pend_clr    = 1'b0;
        cnt_inc     = 1'b0;
        case (op_reg)
            mdtm_pkg::OP_ADD:
            begin
                if (free_found_reg)
                begin
                    r_slot      = 4'(free_idx_reg);
                    r_notice    = !block_reg && !pending_reg;
                    pend_set    = r_notice;
                    act_set     = 1'b1;
                    act_addr    = free_idx_reg;
                    rep_wr      = 1'b1;
                    wr_dl_en    = 1'b1;
                    wr_dl_addr  = free_idx_reg;
                    wr_ivl_en   = 1'b1;
                    wr_ivl_addr = free_idx_reg;
                end
                else
                begin
                    r_status = mdtm_pkg::ST_FULL;
                end
            end
            mdtm_pkg::OP_CANCEL:
            begin
                if (id_ok && id_act)
                begin
                    act_clr = 1'b1;
                end
                else
                begin
                    r_status = mdtm_pkg::ST_INACTIVE;
                end
            end
            mdtm_pkg::OP_REFRESH:
            begin
                if (id_ok && id_act)
                begin
                    wr_dl_en = 1'b1;
                end
                else
                begin
                    r_status = mdtm_pkg::ST_INACTIVE;
                end
            end
            mdtm_pkg::OP_RESET:
            begin
                if (!id_ok)
                begin
                    r_status = mdtm_pkg::ST_INACTIVE;
                end
                else if (short_reg)
                begin
                    r_status = mdtm_pkg::ST_OK;
                end
                else if (!id_act)
                begin
                    r_status = mdtm_pkg::ST_INACTIVE;
                end
                else
                begin
                    r_notice  = !block_reg && !pending_reg;
                    pend_set  = r_notice;
                    wr_dl_en  = 1'b1;
                    wr_ivl_en = 1'b1;
                end
            end
            mdtm_pkg::OP_SCAN:
            begin
                if (scan_sel_reg && found_reg)
                begin
                    r_slot     = 4'(best_idx_reg);
                    r_exp      = 1'b1;
                    r_last     = !more_reg || (emit_cnt_reg == LAST_CNT);
                    due_clr    = 1'b1;
                    cnt_inc    = 1'b1;
                    act_addr   = best_idx_reg;
                    wr_dl_addr = best_idx_reg;
                    wr_dl_data = now_reg + 64'(best_ivl_reg);
                    wr_dl_en   = best_rep_reg;
                    act_clr    = !best_rep_reg;
                end
            end
            mdtm_pkg::OP_QUERY:
            begin
                pend_clr = 1'b1;
                if (!found_reg)
                begin
                    r_delay = '1;
                end
                else if (now_reg >= best_dl_reg)
                begin
                    r_delay = '0;
                end
                else
                begin
                    r_delay = best_dl_reg - now_reg;
                end
            end
            default:
            begin
                r_status = mdtm_pkg::ST_OK;
            end
        endcase
    end

    // item latch and per item arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            now_reg  <= now_ms;
            id_reg   <= timer_id;
            ivl_reg  <= interval_ms;
            rec_reg  <= recurring;
            fnow_reg <= restart_now;
        end
        if (cmd.calc)
        begin
            short_reg    <= short_w;
            roll_sum_reg <= {1'b0, now_reg} + 65'(rollover_reg);
            if (op_reg == mdtm_pkg::OP_REFRESH)
            begin
                new_dl_reg <= now_reg + 64'(rd_ivl_reg);
            end
            else if ((op_reg == mdtm_pkg::OP_RESET) && !fnow_reg)
            begin
                new_dl_reg <= rd_dl_reg - 64'(rd_ivl_reg) + 64'(ivl_reg);
            end
            else
            begin
                new_dl_reg <= now_reg + 64'(ivl_reg);
            end
        end
    end

    // slot memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.emit && wr_dl_en)
        begin
            dl_mem[wr_dl_addr] <= wr_dl_data;
        end
        if (cmd.emit && wr_ivl_en)
        begin
            ivl_mem[wr_ivl_addr] <= ivl_reg;
        end
        if (cmd.rd_id || issue)
        begin
            rd_dl_reg  <= dl_mem[rd_addr];
            rd_ivl_reg <= ivl_mem[rd_addr];
        end
        if (cmd.emit && rep_wr)
        begin
            rep_reg[act_addr] <= rec_reg;
        end
        p_idx_reg <= idx_reg;
    end

    // sweep accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_start)
        begin
            found_reg      <= 1'b0;
            more_reg       <= 1'b0;
            block_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            any_reg        <= 1'b0;
        end
        else if (p_vld_reg)
        begin
            case (op_reg)
                mdtm_pkg::OP_ADD:
                begin
                    if (!p_act)
                    begin
                        if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= p_idx_reg;
                        end
                    end
                    else if (free_found_reg ? (rd_dl_reg < new_dl_reg)
                                            : (rd_dl_reg <= new_dl_reg))
                    begin
                        block_reg <= 1'b1;
                    end
                end
                mdtm_pkg::OP_RESET:
                begin
                    if (p_act && (p_idx_reg != id_idx) && ((rd_dl_reg < new_dl_reg)
                        || ((rd_dl_reg == new_dl_reg) && (p_idx_reg < id_idx))))
                    begin
                        block_reg <= 1'b1;
                    end
                end
                mdtm_pkg::OP_QUERY:
                begin
                    if (p_act && (!found_reg || (rd_dl_reg < best_dl_reg)))
                    begin
                        found_reg   <= 1'b1;
                        best_dl_reg <= rd_dl_reg;
                    end
                end
                mdtm_pkg::OP_SCAN:
                begin
                    if (!scan_sel_reg)
                    begin
                        any_reg <= any_reg | p_act;
                    end
                    else if (due_reg[p_idx_reg])
                    begin
                        if (found_reg)
                        begin
                            more_reg <= 1'b1;
                        end
                        if (!found_reg || (rd_dl_reg < best_dl_reg))
                        begin
                            found_reg    <= 1'b1;
                            best_dl_reg  <= rd_dl_reg;
                            best_idx_reg <= p_idx_reg;
                            best_ivl_reg <= rd_ivl_reg;
                            best_rep_reg <= p_rep;
                        end
                    end
                end
                default:
                begin
                    any_reg <= any_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                active_reg[i] <= 1'b0;
                due_reg[i]    <= 1'b0;
            end
            last_scan_reg <= '0;
            pending_reg   <= 1'b0;
            rollover_reg  <= mdtm_pkg::ROLLOVER_DEF;
            scan_sel_reg  <= 1'b0;
            emit_cnt_reg  <= '0;
            idx_reg       <= '0;
            iss_done_reg  <= 1'b0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                rollover_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                scan_sel_reg <= 1'b0;
            end
            if (cmd.scan_begin)
            begin
                scan_sel_reg  <= 1'b1;
                last_scan_reg <= now_reg;
                emit_cnt_reg  <= '0;
            end
            if (cmd.sweep_start)
            begin
                idx_reg      <= '0;
                iss_done_reg <= 1'b0;
                p_vld_reg    <= 1'b0;
            end
            else
            begin
                p_vld_reg <= issue;
                if (issue)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        iss_done_reg <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
            end
            if (p_vld_reg && (op_reg == mdtm_pkg::OP_SCAN) && !scan_sel_reg)
            begin
                due_reg[p_idx_reg] <= p_act && (roll_w || (rd_dl_reg <= now_reg));
            end
            if (cmd.emit)
            begin
                if (act_set)
                begin
                    active_reg[act_addr] <= 1'b1;
                end
                if (act_clr)
                begin
                    active_reg[act_addr] <= 1'b0;
                end
                if (due_clr)
                begin
                    due_reg[best_idx_reg] <= 1'b0;
                end
                if (cnt_inc)
                begin
                    emit_cnt_reg <= emit_cnt_reg + 1'b1;
                end
                if (pend_set)
                begin
                    pending_reg <= 1'b1;
                end
                if (pend_clr)
                begin
                    pending_reg <= 1'b0;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg  <= r_status;
            slot_reg    <= r_slot;
            expired_reg <= r_exp;
            notice_reg  <= r_notice;
            delay_reg   <= r_delay;
            last_reg    <= r_last;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot_out     = slot_reg;
    assign expired      = expired_reg;
    assign front_notice = notice_reg;
    assign delay_ms     = delay_reg;
    assign last         = last_reg;

endmodule

[rtl/multi_slot_deadline_timer_manager.sv]
// top level of the deadline timer manager: channels, controller and datapath
// depends on mdtm_pkg, mdtm_if, mdtm_ctrl and mdtm_datapath

// A table of NUM_TIMERS timer slots, each with interval, deadline, recurring flag
// and active mark. Each request carries the current time and one operation (add,
// cancel, refresh, reset, expire scan, next-delay query); it is answered by one
// response transaction, or by one per expired slot (up to 16) for a scan, the
// final one marked by last. One request is handled at a time. Add, query and a
// scan of an empty table sweep every slot through the deadline memory read port,
// as does a reset that moves a deadline; cancel, refresh, a reset that moves
// nothing and unused codes do not sweep.
// A scan of a non-empty table runs one sweep to mark due slots and one more per
// reported slot (at least one), with one emit per response. The single memory
// read port reads one slot per cycle during a sweep; a stalled receiver holds
// the block in its emit state until the output register is free. A response
// waiting in the output register does not block the next request, only the
// next response.
// rollover_ms may be written at any time the block is idle; cfg is always ready.
module multi_slot_deadline_timer_manager #(
    parameter int NUM_TIMERS = mdtm_pkg::NUM_TIMERS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    mdtm_req_if.sink   req,
    mdtm_rsp_if.source rsp,
    mdtm_cfg_if.sink   cfg
);

    mdtm_pkg::cmd_t    cmd;
    mdtm_pkg::status_t st;
    logic              req_ready;

    // config register always takes a transaction
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    // sequencer: idle / prepare / decide / sweep / emit
    mdtm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // slot tables, sweep accumulators and the response register
    mdtm_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .operation    (req.operation),
        .now_ms       (req.now_ms),
        .timer_id     (req.timer_id),
        .interval_ms  (req.interval_ms),
        .recurring    (req.recurring),
        .restart_now  (req.restart_now),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .status       (rsp.status),
        .slot_out     (rsp.slot_out),
        .expired      (rsp.expired),
        .front_notice (rsp.front_notice),
        .delay_ms     (rsp.delay_ms),
        .last         (rsp.last)
    );

    // an accepted request keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted twice in a row");

    // a response is loaded only when the output register can take it
    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("response register overwritten");

    // an expiry report carries no delay, no notice and ok status
    a_expiry_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.expired) |->
            (rsp.delay_ms == 64'd0) && !rsp.front_notice && (rsp.status == mdtm_pkg::ST_OK))
        else $error("malformed expiry response");

endmodule

[tb/mdtm_tb_checker.sv]
// scoreboard of the deadline timer manager: watches req, rsp and cfg, predicts, compares
// depends on mdtm_pkg and mdtm_if
module mdtm_tb_checker (
    input  logic        clk,
    input  logic        rst_n,
    mdtm_req_if         req,
    mdtm_rsp_if         rsp,
    mdtm_cfg_if         cfg,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = mdtm_pkg::NUM_TIMERS_DEF;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_out;
        logic        expired;
        logic        front_notice;
        logic [63:0] delay_ms;
        logic        last;
    } timer_result_t;

    logic        act [NT];
    logic [31:0] ivl_tab [NT];
    logic [63:0] dl_tab [NT];
    logic        rep_tab [NT];
    logic [63:0] scan_time;
    logic        notice;
    logic [31:0] rollover;
    timer_result_t expected_results[$];

    function automatic bit earlier(int a, int b);
        if (dl_tab[a] != dl_tab[b]) return dl_tab[a] < dl_tab[b];
        return a < b;
    endfunction

    function automatic logic raise_notice(int s);
        bit first;
        first = 1;
        for (int i = 0; i < NT; i++)
            if (i != s && act[i] && earlier(i, s)) first = 0;
        if (first && !notice)
        begin
            notice = 1;
            return 1;
        end
        return 0;
    endfunction

    function automatic timer_result_t mk(logic [1:0] st, logic [3:0] sl, logic ex,
                                          logic fn, logic [63:0] d, logic l);
        timer_result_t r;
        r.status = st; r.slot_out = sl; r.expired = ex;
        r.front_notice = fn; r.delay_ms = d; r.last = l;
        return r;
    endfunction

    // append one expected response at the tail of the queue
    function automatic void queue_expect(timer_result_t r);
        expected_results = {expected_results, r};
    endfunction

    task automatic predict_request(logic [2:0] op, logic [63:0] now, logic [3:0] id,
                                   logic [31:0] ivl, logic rec, logic fnow);
        bit found, roll;
        bit due [NT];
        int order[$];
        int best;
        logic [63:0] bd, start;
        case (op)
            mdtm_pkg::OP_ADD:
            begin
                found = 0;
                for (int i = 0; i < NT && !found; i++)
                    if (!act[i])
                    begin
                        found = 1;
                        act[i] = 1; ivl_tab[i] = ivl; rep_tab[i] = rec;
                        dl_tab[i] = now + 64'(ivl);
                        queue_expect(mk(mdtm_pkg::ST_OK, 4'(i), 0, raise_notice(i), 0, 1));
                    end
                if (!found) queue_expect(mk(mdtm_pkg::ST_FULL, 0, 0, 0, 0, 1));
            end
            mdtm_pkg::OP_CANCEL, mdtm_pkg::OP_REFRESH:
            begin
                if (!act[id]) queue_expect(mk(mdtm_pkg::ST_INACTIVE, 0, 0, 0, 0, 1));
                else
                begin
                    if (op == mdtm_pkg::OP_CANCEL) act[id] = 0;
                    else dl_tab[id] = now + 64'(ivl_tab[id]);
                    queue_expect(mk(mdtm_pkg::ST_OK, 0, 0, 0, 0, 1));
                end
            end
            mdtm_pkg::OP_RESET:
            begin
                if (ivl == ivl_tab[id] && !fnow)
                    queue_expect(mk(mdtm_pkg::ST_OK, 0, 0, 0, 0, 1));
                else if (!act[id])
                    queue_expect(mk(mdtm_pkg::ST_INACTIVE, 0, 0, 0, 0, 1));
                else
                begin
                    start = fnow ? now : dl_tab[id] - 64'(ivl_tab[id]);
                    ivl_tab[id] = ivl;
                    dl_tab[id] = start + 64'(ivl);
                    queue_expect(mk(mdtm_pkg::ST_OK, 0, 0, raise_notice(id), 0, 1));
                end
            end
            mdtm_pkg::OP_SCAN:
            begin
                found = 0;
                for (int i = 0; i < NT; i++) if (act[i]) found = 1;
                if (found)
                begin
                    roll = now < scan_time && (scan_time - now) > 64'(rollover);
                    scan_time = now;
                    for (int i = 0; i < NT; i++) due[i] = act[i] && (roll || dl_tab[i] <= now);
                    while (order.size() < mdtm_pkg::MAX_RESULTS)
                    begin
                        best = -1;
                        for (int i = 0; i < NT; i++)
                            if (due[i] && (best < 0 || earlier(i, best))) best = i;
                        if (best < 0) break;
                        due[best] = 0;
                        order = {order, best};
                    end
                end
                if (order.size() == 0) queue_expect(mk(mdtm_pkg::ST_OK, 0, 0, 0, 0, 1));
                foreach (order[k])
                begin
                    if (rep_tab[order[k]]) dl_tab[order[k]] = now + 64'(ivl_tab[order[k]]);
                    else act[order[k]] = 0;
                    queue_expect(mk(mdtm_pkg::ST_OK, 4'(order[k]), 1, 0, 0,
                                    k == order.size() - 1));
                end
            end
            mdtm_pkg::OP_QUERY:
            begin
                notice = 0;
                found = 0; bd = 0;
                for (int i = 0; i < NT; i++)
                    if (act[i] && (!found || dl_tab[i] < bd))
                    begin
                        bd = dl_tab[i]; found = 1;
                    end
                queue_expect(mk(mdtm_pkg::ST_OK, 0, 0, 0,
                    !found ? '1 : (now >= bd ? 64'd0 : bd - now), 1));
            end
            default: queue_expect(mk(mdtm_pkg::ST_OK, 0, 0, 0, 0, 1));
        endcase
    endtask

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t got, exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < NT; i++)
            begin
                act[i] = 0; ivl_tab[i] = 0; dl_tab[i] = 0; rep_tab[i] = 0;
            end
            scan_time = 0; notice = 0; rollover = mdtm_pkg::ROLLOVER_DEF;
            expected_results.delete();
            fail_count = 0; result_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready) rollover = cfg.data;
            if (rsp.valid && rsp.ready)
            begin
                got = mk(rsp.status, rsp.slot_out, rsp.expired, rsp.front_notice,
                         rsp.delay_ms, rsp.last);
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected response transaction %p", got);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.status !== exp_r.status)
                    begin
                        $error("status expected %0d got %0d", exp_r.status, got.status);
                        fail_count++;
                    end
                    if (got.slot_out !== exp_r.slot_out)
                    begin
                        $error("slot_out expected %0d got %0d", exp_r.slot_out, got.slot_out);
                        fail_count++;
                    end
                    if (got.expired !== exp_r.expired)
                    begin
                        $error("expired expected %0d got %0d", exp_r.expired, got.expired);
                        fail_count++;
                    end
                    if (got.front_notice !== exp_r.front_notice)
                    begin
                        $error("front_notice expected %0d got %0d",
                               exp_r.front_notice, got.front_notice);
                        fail_count++;
                    end
                    if (got.delay_ms !== exp_r.delay_ms)
                    begin
                        $error("delay_ms expected %0h got %0h", exp_r.delay_ms, got.delay_ms);
                        fail_count++;
                    end
                    if (got.last !== exp_r.last)
                    begin
                        $error("last expected %0d got %0d", exp_r.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_request(req.operation, req.now_ms, req.timer_id, req.interval_ms,
                                req.recurring, req.restart_now);
        end
    end
endmodule

[tb/tb.sv]
// top of the deadline timer manager testbench: clock, reset, stimulus and verdict
// depends on mdtm_pkg, mdtm_if, mdtm_tb_checker and the block itself
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count, pending_count, result_count;

    mdtm_req_if req ();
    mdtm_rsp_if rsp ();
    mdtm_cfg_if cfg ();

    // idle chances in percent, changed per phase
    int send_idle = 0;
    int recv_stall = 0;
    // long receiver hold-off, counted in cycles by its own process
    int hold_cycles = 0;

    // model of the block's time base and of which slots are live, for shaping stimulus
    logic [63:0] now_base = 64'd1000;
    bit          live [16];
    int          items_sent = 0;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    multi_slot_deadline_timer_manager dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    mdtm_tb_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .cfg           (cfg),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    // response ready: random stalls, or held low during a hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 0;
        else if (hold_cycles > 0)
        begin
            rsp.ready <= 0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall);
    end

    // one request transaction; idle gaps drawn before raising valid
    task automatic send_request(logic [2:0] op, logic [63:0] now, logic [3:0] id,
                                logic [31:0] ivl, logic rec, logic fnow);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid       <= 1;
        req.operation   <= op;
        req.now_ms      <= now;
        req.timer_id    <= id;
        req.interval_ms <= ivl;
        req.recurring   <= rec;
        req.restart_now <= fnow;
        do @(posedge clk); while (!req.ready);
        items_sent++;
        if (op == mdtm_pkg::OP_ADD)
        begin
            for (int i = 0; i < 16; i++)
                if (!live[i])
                begin
                    live[i] = 1;
                    break;
                end
        end
        else if (op == mdtm_pkg::OP_CANCEL) live[id] = 0;
    endtask

    task automatic drain_all();
        req.valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        // block may still be finishing internal work
        repeat (80) @(posedge clk);
    endtask

    task automatic write_rollover(logic [31:0] val);
        cfg.valid <= 1;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 0;
    endtask

    // interval mostly small so timers really fall due, sometimes extreme
    function automatic logic [31:0] pick_interval();
        case ($urandom_range(9))
            0: return '1;
            1: return 0;
            2: return $urandom;
            default: return $urandom_range(200);
        endcase
    endfunction

    // a live slot if one of eight random picks finds one, else anything
    function automatic logic [3:0] pick_slot();
        int tries;
        logic [3:0] s;
        for (tries = 0; tries < 8; tries++)
        begin
            s = 4'($urandom_range(15));
            if (live[s]) return s;
        end
        return 4'($urandom_range(15));
    endfunction

    task automatic random_items(int n);
        logic [2:0] op;
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            // time mostly moves forward, now and then jumps far back or to extremes
            if (r < 3) now_base = now_base - 64'($urandom_range(32'd8000000));
            else if (r < 5) now_base = {$urandom, $urandom};
            else now_base = now_base + 64'($urandom_range(60));
            r = $urandom_range(99);
            if (r < 28) op = mdtm_pkg::OP_ADD;
            else if (r < 38) op = mdtm_pkg::OP_CANCEL;
            else if (r < 48) op = mdtm_pkg::OP_REFRESH;
            else if (r < 60) op = mdtm_pkg::OP_RESET;
            else if (r < 82) op = mdtm_pkg::OP_SCAN;
            else if (r < 97) op = mdtm_pkg::OP_QUERY;
            else op = 3'($urandom_range(6, 7));
            send_request(op, now_base, pick_slot(), pick_interval(), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        req.valid = 0; req.operation = mdtm_pkg::OP_QUERY; req.now_ms = 0; req.timer_id = 0;
        req.interval_ms = 0; req.recurring = 0; req.restart_now = 0;
        cfg.valid = 0; cfg.data = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty table scan and query, inactive and unused ops
        send_request(mdtm_pkg::OP_SCAN, 64'd100, 0, 0, 0, 0);
        send_request(mdtm_pkg::OP_QUERY, 64'd100, 0, 0, 0, 0);
        send_request(mdtm_pkg::OP_CANCEL, 64'd100, 4'd15, 0, 0, 0);
        send_request(mdtm_pkg::OP_REFRESH, 64'd100, 4'd3, 0, 0, 0);
        send_request(3'd6, 64'd100, 0, 0, 0, 0);
        send_request(3'd7, '1, 4'd15, '1, 1, 1);
        // fill the whole table with deadlines of 200 and 250, then overflow
        for (int i = 0; i < 16; i++)
            send_request(mdtm_pkg::OP_ADD, 64'd200, 0, (i % 3 == 0) ? 32'd0 : 32'd50, i[0], 0);
        send_request(mdtm_pkg::OP_ADD, 64'd200, 0, 32'd5, 0, 0);
        send_request(mdtm_pkg::OP_RESET, 64'd210, 4'd4, '1, 0, 1);
        send_request(mdtm_pkg::OP_RESET, 64'd210, 4'd5, 32'd50, 0, 0);
        send_request(mdtm_pkg::OP_QUERY, '1, 0, 0, 0, 0);
        // scan with every slot due but slot 4, whose reset moved it far ahead
        send_request(mdtm_pkg::OP_SCAN, 64'd400, 0, 0, 0, 0);
        drain_all();

        // extremes of the register and a backward clock jump
        write_rollover(32'd0);
        for (int i = 0; i < 16; i++) live[i] = 0;
        send_request(mdtm_pkg::OP_ADD, 64'd500, 0, '1, 1, 0);
        send_request(mdtm_pkg::OP_SCAN, 64'd499, 0, 0, 0, 0);
        send_request(mdtm_pkg::OP_SCAN, 64'd498, 0, 0, 0, 0);
        drain_all();
        write_rollover('1);

        // random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle  = (ph == 1) ? 46 : (ph == 3) ? 34 : 0;
            recv_stall = (ph == 2) ? 46 : (ph == 3) ? 34 : 0;
            random_items(95);
            if (ph == 1)
            begin
                // sender pauses until everything has come back
                drain_all();
                write_rollover(32'd100);
            end
            if (ph == 2)
            begin
                // long receiver hold-off while requests keep coming
                hold_cycles = 3000;
                random_items(12);
                drain_all();
                write_rollover(mdtm_pkg::ROLLOVER_DEF);
            end
        end

        drain_all();
        $display("sent %0d requests, checked %0d responses, rollover set to extremes and default",
                 items_sent, result_count);
        $display("phases covered idle sender, stalled receiver, a long hold-off and clock jumps");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
